// ===== sv/perspective_inverse_coord_map_defines.svh =====
// Assertion macros used by the checker file.
`ifndef PERSPECTIVE_INVERSE_COORD_MAP_DEFINES_SVH
`define PERSPECTIVE_INVERSE_COORD_MAP_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define PIMAP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pimap check failed");

// Next-cycle implication.
`define PIMAP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pimap check failed");

`endif

// ===== sv/pimap_pkg.sv =====
// ---------------------------------------------------------------------------
// pimap_pkg
// Shared constants and types of the perspective inverse coordinate map.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package pimap_pkg;

  localparam int CoefW    = 48;
  localparam int CoordW   = 12;
  localparam int ProdW    = CoefW + CoordW;      // one coefficient product
  localparam int DenW     = ProdW + 2;           // sum of two products and the constant
  localparam int NumYW    = ProdW + 1;           // sum of two products
  localparam int TW       = DenW + 2;            // 2*n + d
  localparam int RemW     = TW - 1;              // magnitude of t
  localparam int QuoW     = 17;                  // 16 result bits + overflow bit
  localparam int DshW     = RemW + QuoW - 1;     // divisor at its top position
  localparam int DimW     = 13;
  localparam int HalfW    = 12;
  localparam int OutW     = 16;
  localparam int MaxDim   = 4096;
  localparam int DivCells = QuoW;

  localparam int NumRegs  = 8;
  localparam int AddrW    = 6;
  localparam int DataW    = 64;

  typedef enum logic [2:0] {
    REG_DEN_X   = 3'd0,
    REG_DEN_Y   = 3'd1,
    REG_DEN_C   = 3'd2,
    REG_NUMX_X  = 3'd3,
    REG_NUMY_X  = 3'd4,
    REG_NUMY_Y  = 3'd5,
    REG_SRC_W   = 3'd6,
    REG_SRC_H   = 3'd7
  } reg_idx_t;

  // Beat travelling down the divider chain; both quotients share one divisor.
  typedef struct packed {
    logic              valid;
    logic              singular;
    logic              neg_x;
    logic              neg_y;
    logic [RemW-1:0]   rem_x;
    logic [RemW-1:0]   rem_y;
    logic [QuoW-1:0]   quo_x;
    logic [QuoW-1:0]   quo_y;
    logic [DshW-1:0]   dsh;
  } div_t;

endpackage

// ===== sv/pimap_div_cell.sv =====
// ---------------------------------------------------------------------------
// pimap_div_cell
// One restoring-division step for both quotients, registered.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module pimap_div_cell
  import pimap_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  div_t din,
  output div_t dout
);

  div_t step;
  logic ge_x;
  logic ge_y;

  always_comb begin
    ge_x = {{(DshW-RemW){1'b0}}, din.rem_x} >= din.dsh;
    ge_y = {{(DshW-RemW){1'b0}}, din.rem_y} >= din.dsh;
    step = din;
    // when a compare succeeds the divisor does not exceed the remainder, so its low bits suffice
    step.rem_x = ge_x ? din.rem_x - din.dsh[RemW-1:0] : din.rem_x;
    step.rem_y = ge_y ? din.rem_y - din.dsh[RemW-1:0] : din.rem_y;
    step.quo_x = {din.quo_x[QuoW-2:0], ge_x};
    step.quo_y = {din.quo_y[QuoW-2:0], ge_y};
    step.dsh   = din.dsh >> 1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (en) begin
      dout.valid <= step.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout.singular <= step.singular;
      dout.neg_x    <= step.neg_x;
      dout.neg_y    <= step.neg_y;
      dout.rem_x    <= step.rem_x;
      dout.rem_y    <= step.rem_y;
      dout.quo_x    <= step.quo_x;
      dout.quo_y    <= step.quo_y;
      dout.dsh      <= step.dsh;
    end
  end

endmodule

// ===== sv/perspective_inverse_coord_map.sv =====
// Pipeline: multiply, sum, sign normalize, 17 divider cells and the output
// register lie between an input beat and its output beat.
// Throughput: one coordinate per cycle; the whole pipe holds only while an
// output beat waits for out_ready.
// Reset: synchronous rst clears all valid bits and loads the identity warp
// over a 4096 x 4096 source.
// ---------------------------------------------------------------------------
// perspective_inverse_coord_map
// Maps a centered output pixel to its perspective source pixel with flags.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module perspective_inverse_coord_map
  import pimap_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [AddrW-1:0]         paddr,
  input  logic [DataW-1:0]         pwdata,
  output logic [DataW-1:0]         prdata,
  output logic                     pready,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [CoordW-1:0] out_x,
  input  logic signed [CoordW-1:0] out_y,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [OutW-1:0]   src_x,
  output logic signed [OutW-1:0]   src_y,
  output logic                     inside_res,
  output logic                     singular
);

  logic signed [CoefW-1:0] den_x_coef, den_y_coef, den_const;
  logic signed [CoefW-1:0] numx_x_coef, numy_x_coef, numy_y_coef;
  logic [DimW-1:0]         src_width, src_height;
  reg_idx_t                widx;
  logic                    en;

  assign pready = 1'b1;
  assign widx   = reg_idx_t'(paddr[5:3]);

  always_ff @(posedge clk) begin
    if (rst) begin
      den_x_coef  <= '0;
      den_y_coef  <= '0;
      den_const   <= CoefW'(65536);
      numx_x_coef <= CoefW'(65536);
      numy_x_coef <= '0;
      numy_y_coef <= CoefW'(65536);
      src_width   <= DimW'(4096);
      src_height  <= DimW'(4096);
    end else if (psel && penable && pwrite) begin
      case (widx)
        REG_DEN_X:  den_x_coef  <= pwdata[CoefW-1:0];
        REG_DEN_Y:  den_y_coef  <= pwdata[CoefW-1:0];
        REG_DEN_C:  den_const   <= pwdata[CoefW-1:0];
        REG_NUMX_X: numx_x_coef <= pwdata[CoefW-1:0];
        REG_NUMY_X: numy_x_coef <= pwdata[CoefW-1:0];
        REG_NUMY_Y: numy_y_coef <= pwdata[CoefW-1:0];
        REG_SRC_W:  src_width   <= pwdata[DimW-1:0];
        REG_SRC_H:  src_height  <= pwdata[DimW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (widx)
      REG_DEN_X:  prdata = {{(DataW-CoefW){1'b0}}, den_x_coef};
      REG_DEN_Y:  prdata = {{(DataW-CoefW){1'b0}}, den_y_coef};
      REG_DEN_C:  prdata = {{(DataW-CoefW){1'b0}}, den_const};
      REG_NUMX_X: prdata = {{(DataW-CoefW){1'b0}}, numx_x_coef};
      REG_NUMY_X: prdata = {{(DataW-CoefW){1'b0}}, numy_x_coef};
      REG_NUMY_Y: prdata = {{(DataW-CoefW){1'b0}}, numy_y_coef};
      REG_SRC_W:  prdata = {{(DataW-DimW){1'b0}}, src_width};
      REG_SRC_H:  prdata = {{(DataW-DimW){1'b0}}, src_height};
      default:    prdata = '0;
    endcase
  end

  // Single pipe enable: everything moves unless the output beat is stuck.
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // Stage 1: products
  logic                    v1;
  logic signed [ProdW-1:0] p_dx, p_dy, p_nx, p_yx, p_yy;
  logic signed [CoefW-1:0] p_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_dx <= den_x_coef  * out_x;
      p_dy <= den_y_coef  * out_y;
      p_nx <= numx_x_coef * out_x;
      p_yx <= numy_x_coef * out_x;
      p_yy <= numy_y_coef * out_y;
      p_c  <= den_const;
    end
  end

  // Stage 2: sums
  logic                    v2;
  logic signed [DenW-1:0]  den;
  logic signed [ProdW-1:0] num_x;
  logic signed [NumYW-1:0] num_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den   <= DenW'(p_dx) + DenW'(p_dy) + DenW'(p_c);
      num_x <= p_nx;
      num_y <= NumYW'(p_yx) + NumYW'(p_yy);
    end
  end

  // Stage 3: make the divisor positive and fold the +0.5 into t = 2n + d
  logic signed [DenW-1:0] dabs, nxs, nys;
  logic signed [TW-1:0]   tx, ty;
  logic [TW-1:0]          ax, ay;
  div_t                   head;
  div_t                   chain [DivCells+1];

  always_comb begin
    dabs = den[DenW-1] ? -den : den;
    nxs  = den[DenW-1] ? -DenW'(num_x) : DenW'(num_x);
    nys  = den[DenW-1] ? -DenW'(num_y) : DenW'(num_y);
    tx   = (TW'(nxs) <<< 1) + TW'(dabs);
    ty   = (TW'(nys) <<< 1) + TW'(dabs);
    ax   = tx[TW-1] ? TW'(-tx) : TW'(tx);
    ay   = ty[TW-1] ? TW'(-ty) : TW'(ty);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head.valid <= 1'b0;
    end else if (en) begin
      head.valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      head.singular <= (den == '0);
      head.neg_x    <= tx[TW-1];
      head.neg_y    <= ty[TW-1];
      head.rem_x    <= ax[RemW-1:0];
      head.rem_y    <= ay[RemW-1:0];
      head.quo_x    <= '0;
      head.quo_y    <= '0;
      // divisor 2|d| placed at the overflow bit position
      head.dsh      <= {dabs[DenW-1:0], 1'b0, {(QuoW-1){1'b0}}};
    end
  end

  assign chain[0] = head;

  for (genvar k = 0; k < DivCells; k++) begin : g_cell
    pimap_div_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .en   (en),
      .din  (chain[k]),
      .dout (chain[k+1])
    );
  end

  // Output stage: sign, saturation, bounds test
  div_t                   last;
  logic [DimW-1:0]        wc, hc;
  logic [HalfW-1:0]       hw, hh;
  logic signed [OutW-1:0] sx, sy;
  logic signed [OutW:0]   sxe, sye, hwe, hhe;
  logic                   ins;

  assign last = chain[DivCells];

  function automatic logic signed [OutW-1:0] sat_q(input logic neg,
                                                  input logic [QuoW-1:0] q);
    logic signed [OutW-1:0] r;
    if (!neg) begin
      r = (q[QuoW-1] || q[OutW-1]) ? OutW'(32767) : OutW'(q[OutW-1:0]);
    end else if (q[QuoW-1] || (q[OutW-1:0] > OutW'(32768))) begin
      r = OutW'(-32768);
    end else begin
      r = OutW'(-q[OutW-1:0]);
    end
    return r;
  endfunction

  always_comb begin
    wc  = (src_width  > DimW'(MaxDim)) ? DimW'(MaxDim) : src_width;
    hc  = (src_height > DimW'(MaxDim)) ? DimW'(MaxDim) : src_height;
    hw  = wc[DimW-1:1];
    hh  = hc[DimW-1:1];
    sx  = sat_q(last.neg_x, last.quo_x);
    sy  = sat_q(last.neg_y, last.quo_y);
    sxe = {sx[OutW-1], sx};
    sye = {sy[OutW-1], sy};
    hwe = {{(OutW+1-HalfW){1'b0}}, hw};
    hhe = {{(OutW+1-HalfW){1'b0}}, hh};
    ins = (sxe >= -hwe) && (sxe < hwe) && (sye >= -hhe) && (sye < hhe);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= last.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      src_x      <= last.singular ? '0 : sx;
      src_y      <= last.singular ? '0 : sy;
      inside_res <= !last.singular && ins;
      singular   <= last.singular;
    end
  end

endmodule

// ===== sv/pimap_checker.sv =====
// ---------------------------------------------------------------------------
// pimap_checker
// Port-level checks on the coordinate map, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "perspective_inverse_coord_map_defines.svh"

module pimap_checker
  import pimap_pkg::*;
(
  input logic                     clk,
  input logic                     rst,
  input logic                     in_ready,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic signed [OutW-1:0]   src_x,
  input logic signed [OutW-1:0]   src_y,
  input logic                     inside_res,
  input logic                     singular
);

  `PIMAP_ASSERT_NOW(a_singular_zero, out_valid && singular, !inside_res && src_x == '0 && src_y == '0)
  `PIMAP_ASSERT_NOW(a_inside_range, out_valid && inside_res, src_x >= -16'sd2048 && src_x < 16'sd2048 && src_y >= -16'sd2048 && src_y < 16'sd2048)
  `PIMAP_ASSERT_NOW(a_ready_when_empty, !out_valid, in_ready)
  `PIMAP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(src_x) && $stable(src_y))

endmodule

bind perspective_inverse_coord_map pimap_checker u_pimap_checker (
  .clk        (clk),
  .rst        (rst),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .src_x      (src_x),
  .src_y      (src_y),
  .inside_res (inside_res),
  .singular   (singular)
);

// ===== tb/testbench.sv =====
// ---------------------------------------------------------------------------
// Perspective inverse map testbench
// Drives centered output coordinates through the valid/ready input, writes
// the warp coefficients over the register port between phases, and checks
// every result beat against a local predictor of the rounded, saturated
// source coordinate and its inside and singular flags.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import pimap_pkg::*;

  typedef struct packed {
    logic signed [OutW-1:0] sx;
    logic signed [OutW-1:0] sy;
    logic                   in_bounds;
    logic                   sing;
  } map_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [AddrW-1:0] paddr = '0;
  logic [DataW-1:0] pwdata = '0;
  logic [DataW-1:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [CoordW-1:0] out_x = '0, out_y = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [OutW-1:0] src_x, src_y;
  logic inside_res, singular;

  perspective_inverse_coord_map dut (.*);

  always #2 clk = ~clk;

  // warp settings held by the predictor
  logic signed [CoefW-1:0] coef [6];
  logic [DimW-1:0] dim_w, dim_h;

  map_res_t expected_maps[$];
  int errors = 0;
  int cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  task automatic report(input string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  function automatic logic signed [OutW-1:0] round_quot(input logic signed [127:0] n,
                                                        input logic signed [127:0] d);
    logic signed [127:0] t, q;
    if (d < 0) begin
      n = -n;
      d = -d;
    end
    t = 2 * n + d;
    q = t / (2 * d);
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q[OutW-1:0];
  endfunction

  function automatic map_res_t map_coord(input logic signed [CoordW-1:0] x,
                                         input logic signed [CoordW-1:0] y);
    logic signed [127:0] den, nx, ny, hw, hh, sx, sy;
    map_res_t r;
    den = 128'(coef[REG_DEN_X]) * x + 128'(coef[REG_DEN_Y]) * y + 128'(coef[REG_DEN_C]);
    nx = 128'(coef[REG_NUMX_X]) * x;
    ny = 128'(coef[REG_NUMY_X]) * x + 128'(coef[REG_NUMY_Y]) * y;
    r = '0;
    if (den == 0) begin
      r.sing = 1'b1;
      return r;
    end
    r.sx = round_quot(nx, den);
    r.sy = round_quot(ny, den);
    hw = 128'(((dim_w > MaxDim) ? MaxDim : dim_w) / 2);
    hh = 128'(((dim_h > MaxDim) ? MaxDim : dim_h) / 2);
    sx = 128'($signed(r.sx));
    sy = 128'($signed(r.sy));
    r.in_bounds = (sx >= -hw) && (sx < hw) && (sy >= -hh) && (sy < hh);
    return r;
  endfunction

  task automatic write_reg(input reg_idx_t idx, input logic [DataW-1:0] val);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= AddrW'(8 * idx);
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx >= REG_SRC_W) begin
      if (idx == REG_SRC_W) dim_w = val[DimW-1:0];
      else dim_h = val[DimW-1:0];
    end else begin
      coef[idx] = val[CoefW-1:0];
    end
  endtask

  task automatic set_warp(input logic signed [CoefW-1:0] dx, dy, dc, nxx, nyx, nyy,
                          input logic [DimW-1:0] w, h);
    write_reg(REG_DEN_X, DataW'(dx));
    write_reg(REG_DEN_Y, DataW'(dy));
    write_reg(REG_DEN_C, DataW'(dc));
    write_reg(REG_NUMX_X, DataW'(nxx));
    write_reg(REG_NUMY_X, DataW'(nyx));
    write_reg(REG_NUMY_Y, DataW'(nyy));
    write_reg(REG_SRC_W, DataW'(w));
    write_reg(REG_SRC_H, DataW'(h));
  endtask

  // one beat; called at a falling edge, returns at a falling edge with valid
  // still up, so the caller drops it or sends the next beat
  task automatic send_coord(input logic signed [CoordW-1:0] x, y);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    out_x <= x;
    out_y <= y;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_maps.push_back(map_coord(x, y));
    @(negedge clk);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (expected_maps.size() != 0) @(negedge clk);
    repeat (30) @(negedge clk);
  endtask

  function automatic logic signed [CoefW-1:0] rand_coef;
    case ($urandom_range(3))
      0: return CoefW'($signed($urandom_range(131072)) - 65536);
      1: return CoefW'($signed($urandom_range(2000)) - 1000);
      2: return CoefW'({$urandom, $urandom});
      default: return CoefW'($signed($urandom_range(8)) - 4) <<< 16;
    endcase
  endfunction

  task automatic random_coords(input int n);
    repeat (n) begin
      if ($urandom_range(9) == 0)
        send_coord(CoordW'($urandom_range(2) * 2047 - 2048 + 1),
                   $urandom_range(1) ? 12'sh800 : 12'sh7ff);
      else send_coord(CoordW'($urandom), CoordW'($urandom));
    end
  endtask

  task automatic test_directed_identity;
    send_coord(0, 0);
    send_coord(12'sh7ff, 12'sh7ff);
    send_coord(12'sh800, 12'sh800);
    send_coord(12'sh800, 12'sh7ff);
    send_coord(-1, 1);
    send_coord(12'sh555, 12'shaaa);
    drain();
  endtask

  task automatic test_singular_and_saturation;
    // den = x so origin is singular and small x saturates
    set_warp(1, 0, 0, 48'sh7fff_ffff_ffff, 48'sh8000_0000_0000, 48'sh7fff_ffff_ffff,
             13'h1fff, 0);
    send_coord(0, 0);
    send_coord(0, 12'sh7ff);
    send_coord(1, 12'sh7ff);
    send_coord(-1, 12'sh800);
    send_coord(12'sh7ff, 5);
    drain();
    // half-pixel rounding, odd and tiny dimensions
    set_warp(0, 0, 48'sh2_0000, 65536, 0, -65536, 1, 4097);
    send_coord(1, 1);
    send_coord(-1, -1);
    send_coord(3, -3);
    send_coord(0, 0);
    send_coord(12'sh7ff, 12'sh800);
    drain();
    set_warp(0, 0, 48'sh8000_0000_0000, 48'sh8000_0000_0000, 1, 1, 3, 2);
    send_coord(0, 0);
    send_coord(1, -1);
    send_coord(12'sh800, 12'sh800);
    drain();
  endtask

  task automatic test_random_phase(input int idle, stall);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    set_warp(rand_coef(), rand_coef(), rand_coef(), rand_coef(), rand_coef(), rand_coef(),
             DimW'($urandom), DimW'($urandom_range(4096, 1)));
    random_coords(100);
    drain();
  endtask

  task automatic test_hold_off;
    random_coords(20);
    // wait for the pipe to empty mid-stream
    in_valid <= 1'b0;
    while (expected_maps.size() != 0) @(negedge clk);
    random_coords(20);
    drain();
  endtask

  // receiver
  always @(negedge clk) out_ready <= ($urandom_range(99) >= recv_stall_pct);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && out_valid && out_ready) begin
      if (expected_maps.size() == 0) begin
        report("result beat with nothing expected");
      end else begin
        map_res_t e;
        e = expected_maps.pop_front();
        if (src_x !== e.sx) report($sformatf("src_x %0d exp %0d", src_x, e.sx));
        if (src_y !== e.sy) report($sformatf("src_y %0d exp %0d", src_y, e.sy));
        if (inside_res !== e.in_bounds)
          report($sformatf("inside_res %b exp %b", inside_res, e.in_bounds));
        if (singular !== e.sing) report($sformatf("singular %b exp %b", singular, e.sing));
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > 400000) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    coef[REG_DEN_X] = 0;
    coef[REG_DEN_Y] = 0;
    coef[REG_DEN_C] = 65536;
    coef[REG_NUMX_X] = 65536;
    coef[REG_NUMY_X] = 0;
    coef[REG_NUMY_Y] = 65536;
    dim_w = 4096;
    dim_h = 4096;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed_identity();
    test_singular_and_saturation();
    for (int i = 0; i < 2; i++) begin
      test_random_phase(0, 0);
      test_random_phase(60, 0);
      test_random_phase(0, 60);
      test_random_phase(30, 30);
    end
    test_hold_off();
    drain();
    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
